>>> rtl/crc8_frame_receiver_unit_defines.svh
// ---------------------------------------------------------------------------
// CRC-8 frame receiver: assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ---------------------------------------------------------------------------
`ifndef CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CRCFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crcfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CRCFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crcfr: next-cycle check failed");

`endif

>>> rtl/crcfr_pkg.sv
// ---------------------------------------------------------------------------
// CRC-8 frame receiver package
// Frame geometry, CRC constants, register indexes and shared types.
// ---------------------------------------------------------------------------
package crcfr_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_BYTES = 10;
  localparam logic [3:0]  FILL_LAST   = 4'(FRAME_BYTES - 1);

  // CRC-8: polynomial 0x07, zero start value, no reflection, no final xor.
  localparam logic [7:0]  CRC_POLY = 8'h07;
  localparam logic [7:0]  CRC_TOP  = 8'h80;
  localparam logic [7:0]  CRC_INIT = 8'h00;
  localparam int unsigned CRC_SPAN = 8;
  localparam logic [2:0]  CRC_LAST = 3'(CRC_SPAN - 1);

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_COMMAND = 2'd1;
  localparam logic [1:0] REG_TAIL    = 2'd2;

  localparam logic [7:0] HEAD_RESET    = 8'd170;
  localparam logic [7:0] COMMAND_RESET = 8'd2;
  localparam logic [7:0] TAIL_RESET    = 8'd85;

  // Whole frame as seen at the fixed taps of the store.
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // Control of the frame store.
  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_idx;
    logic [7:0] wr_data;
    logic       shift;
  } store_ctl_t;

  // Control of the CRC unit.
  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctl_t;

  // One byte through the CRC-8 register, most significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crcfr_if.sv
// ---------------------------------------------------------------------------
// CRC-8 frame receiver channel interfaces
// Valid/ready channels for received bytes and for frame verdicts.
// ---------------------------------------------------------------------------

// Received byte channel.
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Frame verdict channel.
interface crcfr_out_if;
  logic               valid;
  logic               ready;
  logic               frame_good;
  logic [7:0]         sequence_res;
  logic [7:0]         status_byte;
  logic signed [15:0] speed_forward;
  logic signed [15:0] speed_right;

  modport source (output valid, output frame_good, output sequence_res,
                  output status_byte, output speed_forward, output speed_right,
                  input ready);
  modport sink (input valid, input frame_good, input sequence_res,
                input status_byte, input speed_forward, input speed_right,
                output ready);
endinterface

>>> rtl/crc8_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// CRC-8 frame receiver
// Collects ten-byte frames from a byte stream, checks them and reports them.
// ---------------------------------------------------------------------------
// Each received byte that does not complete a frame is taken while the
// sequencer is idle. The byte that completes a frame starts a check: the
// CRC-8 unit folds in bytes 0 to 7 at one byte per cycle, the check state
// gives the verdict, and a rejected frame is then realigned by shifting the
// store down one byte per cycle until a head byte reaches the front or no
// byte is left to inspect. A completing byte therefore keeps the input
// stalled through the CRC walk, the verdict and any realignment. The verdict
// waits in an output register; the input keeps flowing until a further frame
// would complete while it is still untaken. Bytes other than the head byte
// are dropped while the store is empty.
module crc8_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  crcfr_in_if.sink    in_if,
  crcfr_out_if.source out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  `include "crc8_frame_receiver_unit_defines.svh"

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CRC   = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_ALIGN = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] fill_r, fill_nxt;
  logic [2:0] crc_idx_r, crc_idx_nxt;
  logic [3:0] align_cnt_r, align_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] head_r, cmd_r, tail_r;

  logic               good_r;
  logic [7:0]         seq_r;
  logic [7:0]         status_r;
  logic signed [15:0] fwd_r;
  logic signed [15:0] right_r;

  crcfr_pkg::store_ctl_t store_ctl;
  crcfr_pkg::crc_ctl_t   crc_ctl;
  crcfr_pkg::frame_t     frame;
  logic [7:0]            crc_data;
  logic [7:0]            crc_val;

  logic in_fire;
  logic out_fire;
  logic frame_ok;
  logic load_out;

  // Frame store and CRC unit.
  crcfr_store u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .rd_idx  (crc_idx_r),
    .rd_data (crc_data),
    .frame   (frame)
  );

  crcfr_crc_unit u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (crc_data),
    .crc  (crc_val)
  );

  // Handshakes. A byte that would complete a frame waits while a verdict is pending.
  assign in_if.ready = (state_r == ST_IDLE) &&
                       !(out_valid_r && (fill_r == crcfr_pkg::FILL_LAST));
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_r && out_if.ready;

  assign frame_ok = (frame[1] == cmd_r) && (frame[9] == tail_r) && (frame[8] == crc_val);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= crcfr_pkg::HEAD_RESET;
      cmd_r  <= crcfr_pkg::COMMAND_RESET;
      tail_r <= crcfr_pkg::TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crcfr_pkg::REG_HEAD:    head_r <= cfg_wdata;
        crcfr_pkg::REG_COMMAND: cmd_r  <= cfg_wdata;
        crcfr_pkg::REG_TAIL:    tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: collect, CRC walk, verdict, realign.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    crc_idx_nxt   = crc_idx_r;
    align_cnt_nxt = align_cnt_r;
    out_valid_nxt = out_valid_r && !out_fire;
    load_out      = 1'b0;
    store_ctl     = '{wr_en: 1'b0, wr_idx: fill_r, wr_data: in_if.rx_byte, shift: 1'b0};
    crc_ctl       = '{clear: 1'b0, step: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !((fill_r == 4'd0) && (in_if.rx_byte != head_r))) begin
          store_ctl.wr_en = 1'b1;
          if (fill_r == crcfr_pkg::FILL_LAST) begin
            crc_ctl.clear = 1'b1;
            crc_idx_nxt   = 3'd0;
            state_nxt     = ST_CRC;
          end else begin
            fill_nxt = fill_r + 4'd1;
          end
        end
      end
      ST_CRC: begin
        crc_ctl.step = 1'b1;
        crc_idx_nxt  = crc_idx_r + 3'd1;
        if (crc_idx_r == crcfr_pkg::CRC_LAST) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        if (frame_ok) begin
          fill_nxt  = 4'd0;
          state_nxt = ST_IDLE;
        end else begin
          align_cnt_nxt = 4'(crcfr_pkg::FRAME_BYTES);
          state_nxt     = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // The byte now at position 1 reaches the front with this shift.
        store_ctl.shift = 1'b1;
        align_cnt_nxt   = align_cnt_r - 4'd1;
        if (frame[1] == head_r) begin
          fill_nxt  = align_cnt_r - 4'd1;
          state_nxt = ST_IDLE;
        end else if (align_cnt_r == 4'd2) begin
          fill_nxt  = 4'd0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= 4'd0;
      crc_idx_r   <= 3'd0;
      align_cnt_r <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      crc_idx_r   <= crc_idx_nxt;
      align_cnt_r <= align_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verdict register; a rejected frame reports zero fields.
  always_ff @(posedge clk) begin
    if (load_out) begin
      good_r   <= frame_ok;
      seq_r    <= frame_ok ? frame[2] : 8'h00;
      status_r <= frame_ok ? frame[3] : 8'h00;
      fwd_r    <= frame_ok ? signed'({frame[5], frame[4]}) : 16'sd0;
      right_r  <= frame_ok ? signed'({frame[7], frame[6]}) : 16'sd0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.frame_good    = good_r;
  assign out_if.sequence_res  = seq_r;
  assign out_if.status_byte   = status_r;
  assign out_if.speed_forward = fwd_r;
  assign out_if.speed_right   = right_r;

  // A verdict is only formed when the output register is free.
  `CRCFR_ASSERT_IMP(a_check_out_free, clk, rst_n, state_r == ST_CHECK, !out_valid_r)

  // The completing byte starts the CRC walk on the next cycle.
  `CRCFR_ASSERT_NXT(a_full_starts_crc, clk, rst_n,
                    in_fire && (fill_r == crcfr_pkg::FILL_LAST) && (state_r == ST_IDLE),
                    state_r == ST_CRC)

  // Realignment always has at least one byte left to inspect.
  `CRCFR_ASSERT_IMP(a_align_count, clk, rst_n, state_r == ST_ALIGN, align_cnt_r >= 4'd2)

  // A rejected frame carries only zero fields.
  `CRCFR_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid_r && !good_r,
                    (seq_r == 8'h00) && (status_r == 8'h00) && (fwd_r == 16'sd0) &&
                    (right_r == 16'sd0))

endmodule

>>> rtl/crcfr_crc_unit.sv
// ---------------------------------------------------------------------------
// CRC-8 accumulator
// Folds one frame byte per cycle, while step is set, into a CRC-8 register (poly 0x07).
// ---------------------------------------------------------------------------
module crcfr_crc_unit (
  input  logic                clk,
  input  crcfr_pkg::crc_ctl_t ctl,
  input  logic [7:0]          data,
  output logic [7:0]          crc
);

  logic [7:0] acc_r;
  logic [7:0] acc_nxt;

  // Clear starts a new frame; a step absorbs one byte.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = crcfr_pkg::CRC_INIT;
    end else if (ctl.step) begin
      acc_nxt = crcfr_pkg::crc8_byte(acc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign crc = acc_r;

endmodule

>>> rtl/crcfr_store.sv
// ---------------------------------------------------------------------------
// Frame store
// Ten byte registers, written at the fill position or shifted down by one.
// ---------------------------------------------------------------------------
module crcfr_store (
  input  logic                  clk,
  input  crcfr_pkg::store_ctl_t ctl,
  input  logic [2:0]            rd_idx,
  output logic [7:0]            rd_data,
  output crcfr_pkg::frame_t     frame
);

  crcfr_pkg::frame_t mem_r;

  // A shift moves every byte one place towards the head; the top byte stays.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int j = 0; j < crcfr_pkg::FRAME_BYTES - 1; j++) begin
        mem_r[j] <= mem_r[j+1];
      end
    end else if (ctl.wr_en) begin
      mem_r[ctl.wr_idx] <= ctl.wr_data;
    end
  end

  // Read port for the CRC walk over the first eight bytes.
  assign rd_data = mem_r[rd_idx];
  assign frame   = mem_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CRC-8 frame receiver testbench
// Feeds byte streams of good, corrupted, truncated and noisy frames through
// the receiver under several register settings. A scoreboard class tracks
// the frame store and predicts each verdict, which is checked field by field
// against the result channel. Both channels idle at random in bursts, but for the last phase.
// ---------------------------------------------------------------------------
module tb_top;
  import crcfr_pkg::*;

  // Index beyond the register list; a write to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_BYTES    = 305;

  typedef logic [7:0] frame_bytes_t [FRAME_BYTES];

  typedef struct packed {
    logic               good;
    logic [7:0]         seq;
    logic [7:0]         status;
    logic signed [15:0] fwd;
    logic signed [15:0] right;
  } verdict_t;

  // Tracks the receiver's store and registers and predicts frame verdicts.
  class frame_checker;
    logic [7:0]  head_cfg = HEAD_RESET;
    logic [7:0]  cmd_cfg  = COMMAND_RESET;
    logic [7:0]  tail_cfg = TAIL_RESET;
    frame_bytes_t store;
    int unsigned fill;
    int unsigned stored;
    int unsigned errors;
    verdict_t    verdict_q[$];

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_HEAD:    head_cfg = val;
        REG_COMMAND: cmd_cfg  = val;
        REG_TAIL:    tail_cfg = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] crc8(frame_bytes_t f);
      logic [7:0] acc;
      acc = CRC_INIT;
      for (int k = 0; k < CRC_SPAN; k++) begin
        acc = acc ^ f[k];
        for (int b = 0; b < 8; b++) begin
          if ((acc & CRC_TOP) != 8'h00) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
          end else begin
            acc = {acc[6:0], 1'b0};
          end
        end
      end
      return acc;
    endfunction

    function int unsigned held();
      return fill;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // Applies one accepted byte transaction to the predicted store.
    function void note_byte(logic [7:0] b);
      verdict_t v;
      int unsigned keep;
      if (fill == 0 && b != head_cfg) begin
        return;
      end
      stored++;
      store[fill] = b;
      fill++;
      if (fill < FRAME_BYTES) begin
        return;
      end
      v = '0;
      if (store[1] == cmd_cfg && store[9] == tail_cfg && store[8] == crc8(store)) begin
        v.good   = 1'b1;
        v.seq    = store[2];
        v.status = store[3];
        v.fwd    = {store[5], store[4]};
        v.right  = {store[7], store[6]};
        fill = 0;
      end else begin
        // Resync on the first head byte after the front, or drop everything.
        fill = 0;
        for (int i = 1; i < FRAME_BYTES; i++) begin
          if (store[i] == head_cfg) begin
            keep = FRAME_BYTES - i;
            for (int j = 0; j < keep; j++) begin
              store[j] = store[i + j];
            end
            fill = keep;
            break;
          end
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void report(string what, verdict_t exp_v, verdict_t got);
      if (errors < 10) begin
        $display("mismatch %s: expected good=%0d seq=%02h status=%02h fwd=%0d right=%0d",
                 what, exp_v.good, exp_v.seq, exp_v.status, exp_v.fwd, exp_v.right);
        $display("  actual good=%0d seq=%02h status=%02h fwd=%0d right=%0d",
                 got.good, got.seq, got.status, got.fwd, got.right);
      end
      errors++;
    endfunction

    // Compares one accepted verdict transaction with the oldest prediction.
    function void check_verdict(verdict_t got);
      verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        report("(no verdict pending)", '0, got);
        return;
      end
      exp_v = verdict_q.pop_front();
      if (got.good !== exp_v.good) begin
        report("frame_good", exp_v, got);
      end else if (got.seq !== exp_v.seq) begin
        report("sequence_res", exp_v, got);
      end else if (got.status !== exp_v.status) begin
        report("status_byte", exp_v, got);
      end else if (got.fwd !== exp_v.fwd) begin
        report("speed_forward", exp_v, got);
      end else if (got.right !== exp_v.right) begin
        report("speed_right", exp_v, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       quiet;
  logic       in_idle_on;
  int unsigned idle_cycles;

  frame_checker sb = new();

  crcfr_in_if  in_ch ();
  crcfr_out_if out_ch ();

  crc8_frame_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Known values on every input from time zero.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_HEAD;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    quiet         = 1'b0;
    in_idle_on    = 1'b0;
  end

  // Result-side back-pressure: bursts of stall, with calm stretches between.
  initial begin
    bit stall_on;
    int unsigned window;
    stall_on = 1'b1;
    window   = 0;
    forever begin
      @(negedge clk);
      window++;
      if (window == 100) begin
        window   = 0;
        stall_on = $urandom_range(0, 2) != 0;
      end
      if (!quiet && stall_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Verdict monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_verdict({out_ch.frame_good, out_ch.sequence_res, out_ch.status_byte,
                        out_ch.speed_forward, out_ch.speed_right});
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one byte, with an occasional gap in front of it.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && in_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
  endtask

  task automatic send_frame(input frame_bytes_t f);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      send_byte(f[i]);
    end
  endtask

  // Stops sending and waits until every predicted verdict has arrived and
  // any realignment still running inside the block has had time to end.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] head, input logic [7:0] cmd,
                            input logic [7:0] tail, input bit spare);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    int unsigned n;
    idx[0] = REG_HEAD;    val[0] = head;
    idx[1] = REG_COMMAND; val[1] = cmd;
    idx[2] = REG_TAIL;    val[2] = tail;
    idx[3] = REG_SPARE;   val[3] = 8'($urandom_range(0, 255));
    n = spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = idx[i];
      cfg_wdata = val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] non_head_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == sb.head_cfg);
    return v;
  endfunction

  function automatic frame_bytes_t good_frame();
    frame_bytes_t f;
    f[0] = sb.head_cfg;
    f[1] = sb.cmd_cfg;
    for (int i = 2; i < 8; i++) begin
      f[i] = payload_byte();
    end
    f[8] = sb.crc8(f);
    f[9] = sb.tail_cfg;
    return f;
  endfunction

  // One random stimulus item: well-formed frames half the time, else corrupted,
  // truncated and noise sequences.
  task automatic send_random_item();
    frame_bytes_t f;
    int unsigned pick;
    int unsigned n;
    in_idle_on = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    f = good_frame();
    if (pick < 50) begin
      // Usually flush a part-filled store first so the frame lines up.
      if ($urandom_range(0, 4) != 0) begin
        while (sb.held() != 0) send_byte(non_head_byte());
      end
      send_frame(f);
    end else if (pick < 58) begin
      f[8] = f[8] ^ 8'($urandom_range(1, 255));
      send_frame(f);
    end else if (pick < 64) begin
      f[1] = f[1] ^ 8'($urandom_range(1, 255));
      send_frame(f);
    end else if (pick < 70) begin
      f[9] = f[9] ^ 8'($urandom_range(1, 255));
      send_frame(f);
    end else if (pick < 80) begin
      // A head byte buried in the frame, so a rejection realigns onto it.
      f[$urandom_range(1, FRAME_BYTES - 1)] = sb.head_cfg;
      if ($urandom_range(0, 1) == 0) begin
        f[$urandom_range(1, FRAME_BYTES - 1)] = sb.head_cfg;
      end
      send_frame(f);
    end else if (pick < 88) begin
      n = $urandom_range(1, FRAME_BYTES - 1);
      for (int i = 0; i < n; i++) begin
        send_byte(f[i]);
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned target;
    target = sb.stored + budget;
    while (sb.stored < target) send_random_item();
  endtask

  // Main sequence.
  initial begin
    frame_bytes_t f;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: noise while empty, a good frame with extreme fields, a bad
    // frame that realigns on an inner head, then a frame with no head left.
    send_byte(8'h00);
    send_byte(8'hFF);
    f[0] = HEAD_RESET; f[1] = COMMAND_RESET; f[2] = 8'hFF; f[3] = 8'h00;
    f[4] = 8'h00; f[5] = 8'h80; f[6] = 8'hFF; f[7] = 8'h7F;
    f[8] = sb.crc8(f); f[9] = TAIL_RESET;
    send_frame(f);
    f[0] = HEAD_RESET; f[1] = COMMAND_RESET; f[2] = 8'h11; f[3] = HEAD_RESET;
    f[4] = 8'h22; f[5] = 8'h33; f[6] = 8'h44; f[7] = 8'h55;
    f[8] = sb.crc8(f) ^ 8'h01; f[9] = TAIL_RESET;
    send_frame(f);
    repeat (3) send_byte(8'h00);

    // Hold the sender until every verdict so far has been taken.
    drain();
    run_phase(PHASE_BYTES);

    drain();
    write_regs(8'h00, 8'hFF, 8'h00, 1'b0);
    run_phase(PHASE_BYTES);

    drain();
    write_regs(8'hFF, 8'h00, 8'hFF, 1'b1);
    run_phase(PHASE_BYTES);

    drain();
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b0);
    run_phase(PHASE_BYTES);

    // Last phase back on the reset values, with no idling on either side.
    drain();
    write_regs(HEAD_RESET, COMMAND_RESET, TAIL_RESET, 1'b0);
    quiet = 1'b1;
    run_phase(PHASE_BYTES);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
